// ===== rtl/lprd_pkg.sv =====
// Shared types and constants for the length-prefixed record deframer.
package lprd_pkg;

  localparam int unsigned WORD_BYTES = 4;
  localparam int unsigned POS_W      = $clog2(WORD_BYTES);
  localparam int unsigned ROLE_W     = 4;
  localparam int unsigned WORD_W     = 8 * WORD_BYTES;
  localparam logic [POS_W-1:0] POS_LAST = POS_W'(WORD_BYTES - 1);

  typedef enum logic [ROLE_W-1:0] {
    PH_KEYCOUNT = 4'd0,
    PH_KEYLEN   = 4'd1,
    PH_KEYDATA  = 4'd2,
    PH_VALLEN   = 4'd3,
    PH_VALDATA  = 4'd4,
    PH_ARRCOUNT = 4'd5,
    PH_ARRINDEX = 4'd6,
    PH_ARRLEN   = 4'd7,
    PH_ARRDATA  = 4'd8
  } phase_t;

  typedef struct packed {
    logic [7:0]        byte_out;
    logic [ROLE_W-1:0] role;
    logic [WORD_W-1:0] element_number;
    logic              field_last;
    logic              record_complete;
    logic              partial_dropped;
    logic [WORD_W-1:0] records_so_far;
  } lprd_result_t;

endpackage

// ===== rtl/lprd_if.sv =====
// Valid/ready channel interfaces for the raw byte stream and the tagged byte stream.
interface lprd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_stream;

  modport source (output valid, output data_byte, output end_of_stream, input ready);
  modport sink   (input valid, input data_byte, input end_of_stream, output ready);
endinterface

interface lprd_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  byte_out;
  logic [3:0]  role;
  logic [31:0] element_number;
  logic        field_last;
  logic        record_complete;
  logic        partial_dropped;
  logic [31:0] records_so_far;

  modport source (output valid, output byte_out, output role, output element_number,
                  output field_last, output record_complete, output partial_dropped,
                  output records_so_far, input ready);
  modport sink   (input valid, input byte_out, input role, input element_number,
                  input field_last, input record_complete, input partial_dropped,
                  input records_so_far, output ready);
endinterface

// ===== rtl/length_prefixed_record_deframer.sv =====
// Top level of the length-prefixed record deframer.
//
//   channel   | direction | carries
//   ----------+-----------+-------------------------------------------------
//   raw       | in        | data_byte, end_of_stream
//   deframed  | out       | byte_out, role, element_number, field_last,
//             |           | record_complete, partial_dropped, records_so_far
//
// One byte is taken per clock unless stalled; its tags appear on deframed
// in the next cycle. Word assembly, 32-bit count and length decrement,
// element index and record count increment for a byte are combinational.
// Reset (synchronous, rst) returns the parser to the start of a key count.
// raw.ready drops only while the output register holds a request that
// deframed does not take; the parser state holds while a stall lasts.
module length_prefixed_record_deframer (
  input  logic        clk,
  input  logic        rst,
  lprd_in_if.sink     raw,
  lprd_out_if.source  deframed
);
  import lprd_pkg::*;

  lprd_result_t result;
  logic         can_load;
  logic         accept;

  assign raw.ready = can_load;
  assign accept    = raw.valid && can_load;

  lprd_parse u_parse (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .data_byte     (raw.data_byte),
    .end_of_stream (raw.end_of_stream),
    .result        (result)
  );

  lprd_out_reg u_out_reg (
    .clk      (clk),
    .rst      (rst),
    .load     (accept),
    .result   (result),
    .can_load (can_load),
    .tx       (deframed)
  );

endmodule

// ===== rtl/lprd_parse.sv =====
// Parser state and the per-byte tagging and state update logic.
module lprd_parse (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  accept,
  input  logic [7:0]            data_byte,
  input  logic                  end_of_stream,
  output lprd_pkg::lprd_result_t result
);
  import lprd_pkg::*;

  phase_t            phase, phase_next;
  logic [POS_W-1:0]  length_byte_pos, length_byte_pos_next;
  logic [WORD_W-1:0] word_assembly, word_assembly_next;
  logic [WORD_W-1:0] elements_left, elements_left_next;
  logic [WORD_W-1:0] bytes_left, bytes_left_next;
  logic [WORD_W-1:0] element_index, element_index_next;
  logic [WORD_W-1:0] record_count, record_count_next;

  logic [WORD_W-1:0] word_full;
  logic [WORD_W-1:0] elements_dec;
  logic [WORD_W-1:0] index_inc;
  logic              last_element;
  logic              last_byte;
  logic              word_zero;
  logic              field_last;
  logic              done;
  logic              partial;
  logic [WORD_W-1:0] elem;

  assign word_full    = word_assembly
                        | ({{(WORD_W-8){1'b0}}, data_byte} << {length_byte_pos, 3'b000});
  assign word_zero    = (word_full == '0);
  assign elements_dec = elements_left - WORD_W'(1);
  assign index_inc    = element_index + WORD_W'(1);
  assign last_element = (elements_left == WORD_W'(1));
  assign last_byte    = (bytes_left == WORD_W'(1));

  always_comb begin
    phase_next           = phase;
    length_byte_pos_next = length_byte_pos;
    word_assembly_next   = word_assembly;
    elements_left_next   = elements_left;
    bytes_left_next      = bytes_left;
    element_index_next   = element_index;
    field_last           = 1'b0;
    done                 = 1'b0;

    unique case (phase)
      PH_KEYCOUNT, PH_KEYLEN, PH_VALLEN, PH_ARRCOUNT, PH_ARRLEN: begin
        word_assembly_next   = word_full;
        length_byte_pos_next = length_byte_pos + POS_W'(1);
        if (length_byte_pos == POS_LAST) begin
          word_assembly_next = '0;
          field_last         = 1'b1;
          unique case (phase)
            PH_KEYCOUNT: begin
              elements_left_next = word_full;
              element_index_next = '0;
              phase_next         = word_zero ? PH_VALLEN : PH_KEYLEN;
            end
            PH_KEYLEN: begin
              bytes_left_next = word_full;
              if (word_zero) begin
                // empty key: finish it right here
                element_index_next = index_inc;
                elements_left_next = elements_dec;
                phase_next         = last_element ? PH_VALLEN : PH_KEYLEN;
              end else begin
                phase_next = PH_KEYDATA;
              end
            end
            PH_VALLEN: begin
              bytes_left_next = word_full;
              phase_next      = word_zero ? PH_ARRCOUNT : PH_VALDATA;
            end
            PH_ARRCOUNT: begin
              elements_left_next = word_full;
              element_index_next = '0;
              if (word_zero) begin
                phase_next = PH_KEYCOUNT;
                done       = 1'b1;
              end else begin
                phase_next = PH_ARRINDEX;
              end
            end
            default: begin
              bytes_left_next = word_full;
              if (word_zero) begin
                element_index_next = index_inc;
                elements_left_next = elements_dec;
                done               = last_element;
                phase_next         = last_element ? PH_KEYCOUNT : PH_ARRINDEX;
              end else begin
                phase_next = PH_ARRDATA;
              end
            end
          endcase
        end
      end
      PH_KEYDATA: begin
        bytes_left_next = bytes_left - WORD_W'(1);
        if (last_byte) begin
          field_last         = 1'b1;
          element_index_next = index_inc;
          elements_left_next = elements_dec;
          phase_next         = last_element ? PH_VALLEN : PH_KEYLEN;
        end
      end
      PH_VALDATA: begin
        bytes_left_next = bytes_left - WORD_W'(1);
        if (last_byte) begin
          field_last = 1'b1;
          phase_next = PH_ARRCOUNT;
        end
      end
      PH_ARRINDEX: begin
        field_last = 1'b1;
        phase_next = PH_ARRLEN;
      end
      PH_ARRDATA: begin
        bytes_left_next = bytes_left - WORD_W'(1);
        if (last_byte) begin
          field_last         = 1'b1;
          element_index_next = index_inc;
          elements_left_next = elements_dec;
          done               = last_element;
          phase_next         = last_element ? PH_KEYCOUNT : PH_ARRINDEX;
        end
      end
      default: begin
        // undefined phase code: fall back to the start of a record
        phase_next           = PH_KEYCOUNT;
        length_byte_pos_next = '0;
        word_assembly_next   = '0;
      end
    endcase

    record_count_next = record_count;
    if (done && (record_count != '1)) begin
      record_count_next = record_count + WORD_W'(1);
    end
  end

  // stream ends off a record boundary when the next byte would not open a key count
  assign partial = end_of_stream
                   && !((phase_next == PH_KEYCOUNT) && (length_byte_pos_next == '0));

  always_comb begin
    unique case (phase)
      PH_KEYLEN, PH_KEYDATA, PH_ARRINDEX, PH_ARRLEN, PH_ARRDATA: elem = element_index;
      default:                                                    elem = '0;
    endcase
  end

  always_comb begin
    result.byte_out        = data_byte;
    result.role            = phase;
    result.element_number  = elem;
    result.field_last      = field_last;
    result.record_complete = done;
    result.partial_dropped = partial;
    result.records_so_far  = record_count_next;
  end

  always_ff @(posedge clk) begin
    if (rst || (accept && end_of_stream)) begin
      phase           <= PH_KEYCOUNT;
      length_byte_pos <= '0;
      word_assembly   <= '0;
      elements_left   <= '0;
      bytes_left      <= '0;
      element_index   <= '0;
      record_count    <= '0;
    end else if (accept) begin
      phase           <= phase_next;
      length_byte_pos <= length_byte_pos_next;
      word_assembly   <= word_assembly_next;
      elements_left   <= elements_left_next;
      bytes_left      <= bytes_left_next;
      element_index   <= element_index_next;
      record_count    <= record_count_next;
    end
  end

endmodule

// ===== rtl/lprd_out_reg.sv =====
// Result register that holds one tagged byte until the downstream side takes it.
module lprd_out_reg (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  load,
  input  lprd_pkg::lprd_result_t result,
  output logic                  can_load,
  lprd_out_if.source            tx
);
  import lprd_pkg::*;

  logic         valid;
  lprd_result_t held;

  // take a new request whenever the slot is empty or drains this cycle
  assign can_load = !valid || tx.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (can_load) begin
      valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load && can_load) begin
      held <= result;
    end
  end

  assign tx.valid           = valid;
  assign tx.byte_out        = held.byte_out;
  assign tx.role            = held.role;
  assign tx.element_number  = held.element_number;
  assign tx.field_last      = held.field_last;
  assign tx.record_complete = held.record_complete;
  assign tx.partial_dropped = held.partial_dropped;
  assign tx.records_so_far  = held.records_so_far;

endmodule

// ===== tb/length_prefixed_record_deframer_tb.sv =====
// Self-checking testbench for the length-prefixed record deframer.
`timescale 1ns / 100ps

module length_prefixed_record_deframer_tb;
  import lprd_pkg::*;

  localparam int RANDOM_BYTES = 1200;
  localparam int IDLE_LIMIT   = 2000;
  localparam int MAX_WAIT     = 16;

  // one byte of stimulus; typed_exp marks a row whose tags are written out in the table
  typedef struct packed {
    logic [7:0]   data;
    logic         eos;
    logic         typed_exp;
    lprd_result_t tags;
  } stim_item_t;

  localparam int DIRECTED_ROWS = 26;
  localparam stim_item_t DIRECTED [DIRECTED_ROWS] = '{
    // all-zero record: every section skipped, stream closed on its last byte
    '{8'h00, 1'b0, 1'b1, '{8'h00, PH_KEYCOUNT, 32'd0, 1'b0, 1'b0, 1'b0, 32'd0}},
    '{8'h00, 1'b0, 1'b1, '{8'h00, PH_KEYCOUNT, 32'd0, 1'b0, 1'b0, 1'b0, 32'd0}},
    '{8'h00, 1'b0, 1'b1, '{8'h00, PH_KEYCOUNT, 32'd0, 1'b0, 1'b0, 1'b0, 32'd0}},
    '{8'h00, 1'b0, 1'b1, '{8'h00, PH_KEYCOUNT, 32'd0, 1'b1, 1'b0, 1'b0, 32'd0}},
    '{8'h00, 1'b0, 1'b1, '{8'h00, PH_VALLEN, 32'd0, 1'b0, 1'b0, 1'b0, 32'd0}},
    '{8'h00, 1'b0, 1'b1, '{8'h00, PH_VALLEN, 32'd0, 1'b0, 1'b0, 1'b0, 32'd0}},
    '{8'h00, 1'b0, 1'b1, '{8'h00, PH_VALLEN, 32'd0, 1'b0, 1'b0, 1'b0, 32'd0}},
    '{8'h00, 1'b0, 1'b1, '{8'h00, PH_VALLEN, 32'd0, 1'b1, 1'b0, 1'b0, 32'd0}},
    '{8'h00, 1'b0, 1'b1, '{8'h00, PH_ARRCOUNT, 32'd0, 1'b0, 1'b0, 1'b0, 32'd0}},
    '{8'h00, 1'b0, 1'b1, '{8'h00, PH_ARRCOUNT, 32'd0, 1'b0, 1'b0, 1'b0, 32'd0}},
    '{8'h00, 1'b0, 1'b1, '{8'h00, PH_ARRCOUNT, 32'd0, 1'b0, 1'b0, 1'b0, 32'd0}},
    '{8'h00, 1'b1, 1'b1, '{8'h00, PH_ARRCOUNT, 32'd0, 1'b1, 1'b1, 1'b0, 32'd1}},
    // lone byte of a key count, then end of stream
    '{8'hFF, 1'b1, 1'b1, '{8'hFF, PH_KEYCOUNT, 32'd0, 1'b0, 1'b0, 1'b1, 32'd0}},
    // all-ones key count, stream cut right after the word
    '{8'hFF, 1'b0, 1'b1, '{8'hFF, PH_KEYCOUNT, 32'd0, 1'b0, 1'b0, 1'b0, 32'd0}},
    '{8'hFF, 1'b0, 1'b1, '{8'hFF, PH_KEYCOUNT, 32'd0, 1'b0, 1'b0, 1'b0, 32'd0}},
    '{8'hFF, 1'b0, 1'b1, '{8'hFF, PH_KEYCOUNT, 32'd0, 1'b0, 1'b0, 1'b0, 32'd0}},
    '{8'hFF, 1'b1, 1'b1, '{8'hFF, PH_KEYCOUNT, 32'd0, 1'b1, 1'b0, 1'b1, 32'd0}},
    // one empty key, then end of stream inside the value length
    '{8'h01, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, '0},
    '{8'h80, 1'b1, 1'b0, '0}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;

  lprd_in_if  raw_bus ();
  lprd_out_if deframed_bus ();

  length_prefixed_record_deframer dut (
    .clk      (clk),
    .rst      (rst),
    .raw      (raw_bus),
    .deframed (deframed_bus)
  );

  always #6 clk = ~clk;

  stim_item_t   stim_q [$];
  lprd_result_t pending_tags [$];
  logic         cur_typed;
  lprd_result_t cur_tags;
  int           mismatches;
  int           idle_cycles;

  // deframer state as the testbench tracks it
  phase_t      trk_phase;
  logic [1:0]  trk_pos;
  logic [31:0] trk_word;
  logic [31:0] trk_elems_left;
  logic [31:0] trk_bytes_left;
  logic [31:0] trk_elem_idx;
  logic [31:0] trk_records;

  function automatic void clear_tracker();
    trk_phase      = PH_KEYCOUNT;
    trk_pos        = 2'd0;
    trk_word       = 32'd0;
    trk_elems_left = 32'd0;
    trk_bytes_left = 32'd0;
    trk_elem_idx   = 32'd0;
    trk_records    = 32'd0;
  endfunction

  function automatic void close_key();
    trk_elem_idx   = trk_elem_idx + 32'd1;
    trk_elems_left = trk_elems_left - 32'd1;
    trk_phase      = (trk_elems_left == 32'd0) ? PH_VALLEN : PH_KEYLEN;
  endfunction

  function automatic logic close_array();
    trk_elem_idx   = trk_elem_idx + 32'd1;
    trk_elems_left = trk_elems_left - 32'd1;
    if (trk_elems_left == 32'd0) begin
      trk_phase = PH_KEYCOUNT;
      return 1'b1;
    end
    trk_phase = PH_ARRINDEX;
    return 1'b0;
  endfunction

  // tag one byte and advance the tracked state
  function automatic lprd_result_t deframe_byte(input logic [7:0] b, input logic eos);
    lprd_result_t r;
    logic [31:0]  w;
    logic         done;
    r          = '0;
    done       = 1'b0;
    r.byte_out = b;
    r.role     = trk_phase;
    if (trk_phase inside {PH_KEYLEN, PH_KEYDATA, PH_ARRINDEX, PH_ARRLEN, PH_ARRDATA})
      r.element_number = trk_elem_idx;
    case (trk_phase)
      PH_KEYCOUNT, PH_KEYLEN, PH_VALLEN, PH_ARRCOUNT, PH_ARRLEN: begin
        w        = trk_word | (32'(b) << (8 * trk_pos));
        trk_word = w;
        trk_pos  = trk_pos + 2'd1;
        if (trk_pos == 2'd0) begin
          trk_word     = 32'd0;
          r.field_last = 1'b1;
          case (trk_phase)
            PH_KEYCOUNT: begin
              trk_elems_left = w;
              trk_elem_idx   = 32'd0;
              trk_phase      = (w == 32'd0) ? PH_VALLEN : PH_KEYLEN;
            end
            PH_KEYLEN: begin
              trk_bytes_left = w;
              if (w == 32'd0) close_key();
              else trk_phase = PH_KEYDATA;
            end
            PH_VALLEN: begin
              trk_bytes_left = w;
              trk_phase      = (w == 32'd0) ? PH_ARRCOUNT : PH_VALDATA;
            end
            PH_ARRCOUNT: begin
              trk_elems_left = w;
              trk_elem_idx   = 32'd0;
              if (w == 32'd0) begin
                trk_phase = PH_KEYCOUNT;
                done      = 1'b1;
              end else begin
                trk_phase = PH_ARRINDEX;
              end
            end
            default: begin
              trk_bytes_left = w;
              if (w == 32'd0) done = close_array();
              else trk_phase = PH_ARRDATA;
            end
          endcase
        end
      end
      PH_KEYDATA: begin
        trk_bytes_left = trk_bytes_left - 32'd1;
        if (trk_bytes_left == 32'd0) begin
          r.field_last = 1'b1;
          close_key();
        end
      end
      PH_VALDATA: begin
        trk_bytes_left = trk_bytes_left - 32'd1;
        if (trk_bytes_left == 32'd0) begin
          r.field_last = 1'b1;
          trk_phase    = PH_ARRCOUNT;
        end
      end
      PH_ARRINDEX: begin
        r.field_last = 1'b1;
        trk_phase    = PH_ARRLEN;
      end
      default: begin
        trk_bytes_left = trk_bytes_left - 32'd1;
        if (trk_bytes_left == 32'd0) begin
          r.field_last = 1'b1;
          done         = close_array();
        end
      end
    endcase
    if (done && trk_records != 32'hFFFF_FFFF)
      trk_records = trk_records + 32'd1;
    r.record_complete = done;
    r.partial_dropped = eos && !(trk_phase == PH_KEYCOUNT && trk_pos == 2'd0);
    r.records_so_far  = trk_records;
    if (eos)
      clear_tracker();
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endfunction

  // predict on input acceptance first, then check any result taken in the same cycle
  always @(posedge clk) begin
    lprd_result_t want;
    lprd_result_t predicted;
    logic         moved;
    moved = 1'b0;
    if (rst) begin
      clear_tracker();
    end else begin
      if (raw_bus.valid === 1'b1 && raw_bus.ready === 1'b1) begin
        moved     = 1'b1;
        predicted = deframe_byte(raw_bus.data_byte, raw_bus.end_of_stream);
        pending_tags.insert(pending_tags.size(), cur_typed ? cur_tags : predicted);
      end
      if (deframed_bus.valid === 1'b1 && deframed_bus.ready === 1'b1) begin
        moved = 1'b1;
        if (pending_tags.size() == 0) begin
          $error("tagged byte %0h arrived with no request outstanding",
                 deframed_bus.byte_out);
          mismatches++;
        end else begin
          want = pending_tags.pop_front();
          check_field("byte_out", 32'(want.byte_out), 32'(deframed_bus.byte_out));
          check_field("role", 32'(want.role), 32'(deframed_bus.role));
          check_field("element_number", want.element_number, deframed_bus.element_number);
          check_field("field_last", 32'(want.field_last), 32'(deframed_bus.field_last));
          check_field("record_complete", 32'(want.record_complete),
                      32'(deframed_bus.record_complete));
          check_field("partial_dropped", 32'(want.partial_dropped),
                      32'(deframed_bus.partial_dropped));
          check_field("records_so_far", want.records_so_far, deframed_bus.records_so_far);
        end
      end
    end
    idle_cycles = moved ? 0 : idle_cycles + 1;
  end

  initial begin
    wait (idle_cycles >= IDLE_LIMIT);
    $display("Some tests failed");
    $finish;
  end

  task automatic add_byte(input logic [7:0] b);
    stim_item_t it;
    it      = '0;
    it.data = b;
    stim_q.insert(stim_q.size(), it);
  endtask

  task automatic add_word(input logic [31:0] w);
    for (int i = 0; i < 4; i++)
      add_byte(w[8*i +: 8]);
  endtask

  task automatic close_stream();
    stim_q[stim_q.size() - 1].eos = 1'b1;
  endtask

  // one record with random content; some end the stream, some are cut short
  task automatic add_record();
    int start;
    int mode;
    int cut;
    int n;
    int cnt;
    start = stim_q.size();
    mode  = $urandom_range(0, 15);
    if (mode == 15) begin
      // oversized count or length somewhere, then the stream stops
      case ($urandom_range(0, 4))
        0: ;
        1: add_word(32'd1);
        2: add_word(32'd0);
        3: begin add_word(32'd0); add_word(32'd0); end
        default: begin
          add_word(32'd0);
          add_word(32'd0);
          add_word(32'd1);
          add_byte(8'($urandom));
        end
      endcase
      add_word($urandom | (32'd1 << $urandom_range(8, 31)));
      repeat ($urandom_range(1, 12)) add_byte(8'($urandom));
      close_stream();
    end else begin
      cnt = $urandom_range(0, 2);
      add_word(cnt);
      repeat (cnt) begin
        n = $urandom_range(0, 3);
        add_word(n);
        repeat (n) add_byte(8'($urandom));
      end
      n = $urandom_range(0, 4);
      add_word(n);
      repeat (n) add_byte(8'($urandom));
      cnt = $urandom_range(0, 2);
      add_word(cnt);
      repeat (cnt) begin
        add_byte(8'($urandom));
        n = $urandom_range(0, 3);
        add_word(n);
        repeat (n) add_byte(8'($urandom));
      end
      if (mode >= 13) begin
        cut = $urandom_range(start, stim_q.size() - 1);
        while (stim_q.size() > cut + 1)
          void'(stim_q.pop_back());
        close_stream();
      end else if (mode >= 11) begin
        close_stream();
      end
    end
  endtask

  // sink side: stall a random number of cycles before taking each result
  initial begin
    int  stall;
    bit  calm;
    calm = 1'b0;
    deframed_bus.ready <= 1'b0;
    forever begin
      @(negedge clk);
      if ($urandom_range(0, 39) == 0) calm = !calm;
      stall = calm ? 0 : $urandom_range(0, MAX_WAIT);
      if (stall != 0) begin
        deframed_bus.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      deframed_bus.ready <= 1'b1;
      do @(posedge clk); while (!(deframed_bus.valid === 1'b1 && deframed_bus.ready));
    end
  end

  initial begin
    int  gap;
    bit  calm;
    calm        = 1'b0;
    mismatches  = 0;
    idle_cycles = 0;
    raw_bus.valid         <= 1'b0;
    raw_bus.data_byte     <= 8'h00;
    raw_bus.end_of_stream <= 1'b0;
    cur_typed             <= 1'b0;
    cur_tags              <= '0;

    foreach (DIRECTED[i])
      stim_q.insert(stim_q.size(), DIRECTED[i]);
    while (stim_q.size() < DIRECTED_ROWS + RANDOM_BYTES) begin
      if ($urandom_range(0, 11) == 0) begin
        repeat ($urandom_range(1, 6)) add_byte(8'($urandom));
        close_stream();
      end else begin
        add_record();
      end
    end

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (stim_q[i]) begin
      if ($urandom_range(0, 39) == 0) calm = !calm;
      gap = calm ? 0 : $urandom_range(0, MAX_WAIT);
      if (gap != 0) begin
        raw_bus.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      raw_bus.valid         <= 1'b1;
      raw_bus.data_byte     <= stim_q[i].data;
      raw_bus.end_of_stream <= stim_q[i].eos;
      cur_typed             <= stim_q[i].typed_exp;
      cur_tags              <= stim_q[i].tags;
      do @(posedge clk); while (!(raw_bus.valid && raw_bus.ready === 1'b1));
      @(negedge clk);
    end
    raw_bus.valid <= 1'b0;

    while (pending_tags.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
    if (mismatches == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
